### src/gmis_pkg.sv
// Shared types and constants for the greedy maximal independent set block.
package gmis_pkg;

  localparam int unsigned NODE_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_EDGE  = 2'd1,
    OP_VISIT = 2'd2
  } gmis_op_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } gmis_in_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic               in_set;
    logic [COUNT_W-1:0] set_size;
  } gmis_out_t;

  typedef struct packed {
    logic restart;
    logic sweep_wr;
    logic latch;
    logic edge_wr_a;
    logic edge_wr_b;
    logic visit_rd;
    logic visit_commit;
  } gmis_cmd_t;

  typedef struct packed {
    logic last_row;
    logic out_busy;
  } gmis_status_t;

endpackage

### src/gmis_ctrl.sv
// Controller state machine that sequences clear sweeps, edge writes and node visits.
module gmis_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             op_i,
  output logic                   in_stall_o,
  input  gmis_pkg::gmis_status_t status_i,
  output gmis_pkg::gmis_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EDGE,
    ST_VISIT
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep_wr = 1'b1;
        if (status_i.last_row) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          case (op_i)
            gmis_pkg::OP_CLEAR: begin
              cmd_o.restart = 1'b1;
              state_d       = ST_SWEEP;
            end
            gmis_pkg::OP_EDGE: begin
              cmd_o.edge_wr_a = 1'b1;
              state_d         = ST_EDGE;
            end
            gmis_pkg::OP_VISIT: begin
              cmd_o.visit_rd = 1'b1;
              state_d        = ST_VISIT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_EDGE: begin
        cmd_o.edge_wr_b = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_VISIT: begin
        if (!status_i.out_busy) begin
          cmd_o.visit_commit = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  a_visit_enters_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && op_i == gmis_pkg::OP_VISIT) |=> state_q == ST_VISIT)
    else $error("A visit transaction did not move to the visit state.");

  a_edge_follows_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EDGE) |-> $past(state_q) == ST_IDLE)
    else $error("Second edge write without a preceding edge transaction.");

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.visit_commit |-> !status_i.out_busy)
    else $error("Visit committed while the output register was stalled.");

endmodule

### src/gmis_dp.sv
// Datapath with the adjacency memory, blocked marks, set counter and output register.
module gmis_dp #(
  parameter int unsigned MAX_NODES = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gmis_pkg::gmis_in_t     in_data_i,
  input  gmis_pkg::gmis_cmd_t    cmd_i,
  output gmis_pkg::gmis_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output gmis_pkg::gmis_out_t    out_data_o
);

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned EW = AW + gmis_pkg::NODE_W;

  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_q;
  logic [MAX_NODES-1:0] blocked_q;
  logic [AW-1:0]        sweep_q;
  logic [AW-1:0]        a_idx_q, b_idx_q;
  logic [gmis_pkg::NODE_W-1:0]  node_q;
  logic                 a_ok_q, edge_ok_q;
  logic [gmis_pkg::COUNT_W-1:0] count_q;
  logic                 out_valid_q;
  gmis_pkg::gmis_out_t  out_q;

  logic          in_a_ok, in_b_ok, joined;
  logic          mem_clr, mem_set;
  logic [AW-1:0] in_a_idx, in_b_idx, waddr, wbit;
  logic [gmis_pkg::COUNT_W-1:0] count_inc;

  assign in_a_ok  = EW'(in_data_i.node_a) < EW'(MAX_NODES);
  assign in_b_ok  = EW'(in_data_i.node_b) < EW'(MAX_NODES);
  assign in_a_idx = AW'(in_data_i.node_a);
  assign in_b_idx = AW'(in_data_i.node_b);

  assign joined    = a_ok_q && !blocked_q[a_idx_q];
  assign count_inc = (count_q != gmis_pkg::COUNT_MAX) ? count_q + 1'b1 : count_q;

  assign status_o.last_row = (sweep_q == AW'(MAX_NODES - 1));
  assign status_o.out_busy = out_valid_q && out_stall_i;

  always_comb begin
    mem_clr = 1'b0;
    mem_set = 1'b0;
    waddr   = sweep_q;
    wbit    = '0;
    if (cmd_i.sweep_wr) begin
      mem_clr = 1'b1;
    end else if (cmd_i.edge_wr_a) begin
      mem_set = in_a_ok && in_b_ok;
      waddr   = in_a_idx;
      wbit    = in_b_idx;
    end else if (cmd_i.edge_wr_b) begin
      mem_set = edge_ok_q;
      waddr   = b_idx_q;
      wbit    = a_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_clr) begin
      adj_mem[waddr] <= '0;
    end else if (mem_set) begin
      adj_mem[waddr][wbit] <= 1'b1;
    end
    if (cmd_i.visit_rd) begin
      row_q <= adj_mem[in_a_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      a_idx_q   <= in_a_idx;
      b_idx_q   <= in_b_idx;
      node_q    <= in_data_i.node_a;
      a_ok_q    <= in_a_ok;
      edge_ok_q <= in_a_ok && in_b_ok;
    end
    if (cmd_i.visit_commit) begin
      out_q.node     <= node_q;
      out_q.in_set   <= joined;
      out_q.set_size <= joined ? count_inc : count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= '0;
      blocked_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.restart) begin
        sweep_q   <= '0;
        blocked_q <= '0;
        count_q   <= '0;
      end else if (cmd_i.sweep_wr) begin
        sweep_q <= sweep_q + 1'b1;
      end
      if (cmd_i.visit_commit && joined) begin
        blocked_q <= blocked_q | row_q | (MAX_NODES'(1) << a_idx_q);
        count_q   <= count_inc;
      end
      if (cmd_i.visit_commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.visit_commit))
    else $error("Output became valid without a committed visit.");

  a_member_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.in_set) |-> out_q.set_size != '0)
    else $error("A joining node was reported with an empty set.");

  a_join_blocks_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.visit_commit && joined && !cmd_i.restart) |=> blocked_q[a_idx_q])
    else $error("A joining node was not marked blocked.");

endmodule

### src/greedy_maximal_independent_set.sv
// A visit result is registered when the visit state commits it; that state waits while
// the previous result is still stalled at the output. Edge and visit transactions each
// pass through a second state before the next is accepted, bounded by the single write
// port and the registered row read of the adjacency memory; op 3 stays in idle.
// A clear transaction starts a sweep over all MAX_NODES adjacency rows, one row per cycle.
// Reset runs the same sweep and empties the blocked marks, set count and pending result.
module greedy_maximal_independent_set #(
  parameter int unsigned MAX_NODES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gmis_pkg::gmis_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gmis_pkg::gmis_out_t out_data_o
);

  gmis_pkg::gmis_cmd_t    cmd;
  gmis_pkg::gmis_status_t status;

  gmis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (in_data_i.op),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gmis_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### test/gmis_checker.sv
// Checker that predicts and compares the results of the independent set builder.
`timescale 1ns / 1ps

module gmis_checker #(
  parameter int unsigned NODES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  gmis_pkg::gmis_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  gmis_pkg::gmis_out_t out_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  logic [NODES-1:0]             adj_rows [NODES];
  logic [NODES-1:0]             blocked;
  logic [gmis_pkg::COUNT_W-1:0] member_cnt;
  gmis_pkg::gmis_out_t          visit_results_q [$];

  task automatic clear_graph();
    for (int i = 0; i < NODES; i++) adj_rows[i] = '0;
    blocked    = '0;
    member_cnt = '0;
  endtask

  task automatic log_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic apply_transaction(input gmis_pkg::gmis_in_t t);
    gmis_pkg::gmis_out_t want;
    case (t.op)
      gmis_pkg::OP_CLEAR: begin
        clear_graph();
      end
      gmis_pkg::OP_EDGE: begin
        if (int'(t.node_a) < NODES && int'(t.node_b) < NODES) begin
          adj_rows[t.node_a][t.node_b] = 1'b1;
          adj_rows[t.node_b][t.node_a] = 1'b1;
        end
      end
      gmis_pkg::OP_VISIT: begin
        want.node   = t.node_a;
        want.in_set = 1'b0;
        if (int'(t.node_a) < NODES && !blocked[t.node_a]) begin
          want.in_set         = 1'b1;
          blocked[t.node_a]   = 1'b1;
          blocked             = blocked | adj_rows[t.node_a];
          if (member_cnt != gmis_pkg::COUNT_MAX) member_cnt++;
        end
        want.set_size = member_cnt;
        visit_results_q.insert(visit_results_q.size(), want);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(input gmis_pkg::gmis_out_t got);
    gmis_pkg::gmis_out_t want;
    if (visit_results_q.size() == 0) begin
      log_failure($sformatf("unexpected result node=%0d in_set=%0d set_size=%0d",
                            got.node, got.in_set, got.set_size));
      return;
    end
    want = visit_results_q.pop_front();
    if (got.node !== want.node || got.in_set !== want.in_set ||
        got.set_size !== want.set_size) begin
      log_failure($sformatf({"mismatch: expected node=%0d in_set=%0d set_size=%0d, ",
                             "got node=%0d in_set=%0d set_size=%0d"},
                            want.node, want.in_set, want.set_size,
                            got.node, got.in_set, got.set_size));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count_o = 0;
      clear_graph();
      visit_results_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) apply_transaction(in_data_i);
    end
    pending_o = visit_results_q.size();
  end

endmodule

### test/tb_greedy_maximal_independent_set.sv
// Testbench top for the greedy maximal independent set block.
`timescale 1ns / 1ps

module tb_greedy_maximal_independent_set;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned ITEMS_TOTAL = 1900;
  localparam int unsigned HOLD_AT     = 500;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned LIMIT       = 1000000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  gmis_pkg::gmis_in_t  in_data;
  logic                out_valid;
  logic                out_stall;
  gmis_pkg::gmis_out_t out_data;
  int unsigned         fail_count;
  int unsigned         pending;

  int unsigned items_sent = 0;
  int unsigned cycles     = 0;
  int unsigned tx_quiet   = 0;
  int unsigned rx_quiet   = 0;

  greedy_maximal_independent_set i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  gmis_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, and now and then a stretch without any.
  function automatic int unsigned pick_gap(inout int unsigned quiet_left);
    int unsigned r;
    if (quiet_left != 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) quiet_left = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send(input logic [1:0] op, input logic [7:0] a, input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap(tx_quiet);
    if (gap != 0) begin
      in_valid       = 1'b0;
      in_data.op     = 2'($urandom_range(0, 3));
      in_data.node_a = 8'($urandom);
      in_data.node_b = 8'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid       = 1'b1;
    in_data.op     = op;
    in_data.node_a = a;
    in_data.node_b = b;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_noise();
    int unsigned r;
    logic [1:0]  op;
    r  = $urandom_range(0, 19);
    op = (r == 0) ? gmis_pkg::OP_CLEAR : (r < 8) ? OP_UNUSED :
         (r < 14) ? gmis_pkg::OP_EDGE : gmis_pkg::OP_VISIT;
    send(op, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    logic        hold_done;
    int unsigned stall_len;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (items_sent >= HOLD_AT && !hold_done) begin
        out_stall = 1'b1;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        stall_len = pick_gap(rx_quiet);
        if (stall_len != 0) begin
          out_stall = 1'b1;
          repeat (stall_len) @(negedge clk_i);
        end
      end
      out_stall = 1'b0;
    end
  end

  initial begin
    int unsigned seq_idx;
    int unsigned base;
    int unsigned span;
    int unsigned n_edges;
    int unsigned off;
    int unsigned kind;
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    in_data.op     = gmis_pkg::OP_CLEAR;
    in_data.node_a = '0;
    in_data.node_b = '0;
    seq_idx        = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send(OP_UNUSED,          8'd255, 8'd255);
    send(gmis_pkg::OP_VISIT, 8'd0,   8'd255);
    send(gmis_pkg::OP_VISIT, 8'd0,   8'd0);
    send(gmis_pkg::OP_EDGE,  8'd255, 8'd254);
    send(gmis_pkg::OP_EDGE,  8'd254, 8'd255);
    send(gmis_pkg::OP_EDGE,  8'd1,   8'd1);
    send(gmis_pkg::OP_EDGE,  8'h55,  8'hAA);
    send(gmis_pkg::OP_VISIT, 8'd255, 8'd0);
    send(gmis_pkg::OP_VISIT, 8'd254, 8'd0);
    send(gmis_pkg::OP_VISIT, 8'd1,   8'd0);
    send(gmis_pkg::OP_VISIT, 8'hAA,  8'h55);
    send(gmis_pkg::OP_VISIT, 8'h55,  8'hAA);
    send(gmis_pkg::OP_CLEAR, 8'd255, 8'd255);
    send(gmis_pkg::OP_VISIT, 8'd254, 8'd0);
    send(gmis_pkg::OP_EDGE,  8'd254, 8'd253);
    send(gmis_pkg::OP_VISIT, 8'd253, 8'd0);
    send(gmis_pkg::OP_VISIT, 8'd254, 8'd0);
    send(OP_UNUSED,          8'd0,   8'd0);
    send(gmis_pkg::OP_CLEAR, 8'd0,   8'd0);

    while (items_sent < ITEMS_TOTAL) begin
      kind = $urandom_range(0, 9);
      if (seq_idx == 2 || seq_idx == 15) begin
        // Visit every node once, starting from a random point.
        send(gmis_pkg::OP_CLEAR, 8'($urandom), 8'($urandom));
        n_edges = (seq_idx == 2) ? 0 : $urandom_range(20, 80);
        repeat (n_edges) send(gmis_pkg::OP_EDGE, 8'($urandom), 8'($urandom));
        off = $urandom_range(0, 255);
        for (int i = 0; i < 256; i++) send(gmis_pkg::OP_VISIT, 8'(i + off), 8'($urandom));
      end else if (kind < 7) begin
        send(gmis_pkg::OP_CLEAR, 8'($urandom), 8'($urandom));
        base    = $urandom_range(0, 255);
        span    = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120) :
                                                $urandom_range(3, 40);
        n_edges = $urandom_range(0, 2 * span);
        repeat (n_edges) begin
          if ($urandom_range(0, 15) == 0) send_noise();
          send(gmis_pkg::OP_EDGE, 8'(base + $urandom_range(0, span - 1)),
               8'(base + $urandom_range(0, span - 1)));
        end
        repeat (span + $urandom_range(0, 4)) begin
          if ($urandom_range(0, 15) == 0) send_noise();
          send(gmis_pkg::OP_VISIT, 8'(base + $urandom_range(0, span - 1)), 8'($urandom));
        end
      end else begin
        repeat ($urandom_range(5, 20)) send_noise();
      end
      seq_idx++;
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
